// ----- rtl/core/taet_pkg.sv -----
// ----------------------------------------------------------------------------
// taet_pkg
// Shared types and constants of the trigger action event tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package taet_pkg;

  localparam int unsigned LEVEL_W   = 16;
  localparam int unsigned FRAME_W   = 32;
  localparam int unsigned BTN_W     = 7;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;
  localparam int unsigned MAX_EVT   = 4;
  localparam int unsigned EVT_CNT_W = 3;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_END_LEVEL      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_LEVEL    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COMPLETE_LEVEL = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BUTTON_COUNT   = 2'd3;

  localparam logic [LEVEL_W-1:0] END_LEVEL_RST      = 16'd9830;
  localparam logic [LEVEL_W-1:0] START_LEVEL_RST    = 16'd55705;
  localparam logic [LEVEL_W-1:0] COMPLETE_LEVEL_RST = 16'd58982;
  localparam logic [BTN_W-1:0]   BUTTON_COUNT_RST   = 7'd0;

  typedef enum logic [2:0] {
    ACT_SELECT_START  = 3'd0,
    ACT_SELECT        = 3'd1,
    ACT_SELECT_END    = 3'd2,
    ACT_SQUEEZE_START = 3'd3,
    ACT_SQUEEZE       = 3'd4,
    ACT_SQUEEZE_END   = 3'd5
  } action_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] end_level;
    logic [LEVEL_W-1:0] start_level;
    logic [LEVEL_W-1:0] complete_level;
    logic [BTN_W-1:0]   button_count;
  } cfg_t;

  // events caused by one input transaction, in delivery order
  typedef struct packed {
    logic [EVT_CNT_W-1:0]        count;
    action_t [MAX_EVT-1:0]       codes;
  } evt_bundle_t;

endpackage

`default_nettype wire

// ----- rtl/core/trigger_action_event_tracker_core.sv -----
// ----------------------------------------------------------------------------
// trigger_action_event_tracker_core
// Tracks the select and squeeze triggers and emits their action events.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one transaction per frame update (in_tuser = 0) or disconnect
//           (in_tuser = 1); in_tdata carries frame-id pairs and levels.
//   out_* : one action code per transfer; out_tlast marks the final
//           event caused by an input transaction. Inputs with no event
//           produce nothing on the output.
//   cfg_* : register writes (levels, button count), made by the user only
//           while idle; the block itself does not enforce this.
// Path: accepted inputs pass the bundle queue and the output register to out_*.
// Throughput: the front takes one input per cycle while the bundle queue
//   has room; the back delivers one event per cycle while out_tready is
//   high, so an input with up to 4 events holds the output until all of
//   them are delivered.
// Reset: both triggers return to released, registers take their defaults,
//   queue and output register empty.
// Stall: when out_tready is low the output holds; the queue then fills
//   and in_tready drops until the back frees an entry.
// ----------------------------------------------------------------------------
`default_nettype none

module trigger_action_event_tracker_core #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire         clk,
  input  wire         rst_n,
  // fields from bit 0: select_start_frame, select_stop_frame,
  // squeeze_start_frame, squeeze_stop_frame, select_level, squeeze_level
  input  wire [159:0] in_tdata,
  // fields from bit 0: func
  input  wire         in_tuser,
  input  wire         in_tvalid,
  output logic        in_tready,
  // fields from bit 0: action_code, zero fill
  output logic [7:0]  out_tdata,
  output logic        out_tlast,
  output logic        out_tvalid,
  input  wire         out_tready,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire [taet_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire [taet_pkg::CFG_DAT_W-1:0] cfg_data
);
  import taet_pkg::*;

  cfg_t        cfg_r;
  logic        accept, push, pop, q_full, head_valid;
  evt_bundle_t push_bundle, head;
  action_t     out_code;

  // config registers, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.end_level      <= END_LEVEL_RST;
      cfg_r.start_level    <= START_LEVEL_RST;
      cfg_r.complete_level <= COMPLETE_LEVEL_RST;
      cfg_r.button_count   <= BUTTON_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_END_LEVEL:      cfg_r.end_level      <= cfg_data;
        REG_START_LEVEL:    cfg_r.start_level    <= cfg_data;
        REG_COMPLETE_LEVEL: cfg_r.complete_level <= cfg_data;
        REG_BUTTON_COUNT:   cfg_r.button_count   <= cfg_data[BTN_W-1:0];
        default: ;
      endcase
    end
  end

  // front runs as long as the queue has a free slot
  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  taet_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .accept    (accept),
    .func      (in_tuser),
    .sel_start (in_tdata[31:0]),
    .sel_stop  (in_tdata[63:32]),
    .sqz_start (in_tdata[95:64]),
    .sqz_stop  (in_tdata[127:96]),
    .sel_level (in_tdata[143:128]),
    .sqz_level (in_tdata[159:144]),
    .push      (push),
    .bundle    (push_bundle)
  );

  taet_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_bundle),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  taet_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_code   (out_code),
    .out_last   (out_tlast)
  );

  assign out_tdata = {5'b00000, out_code};

endmodule

`default_nettype wire

// ----- rtl/core/taet_front.sv -----
// ----------------------------------------------------------------------------
// taet_front
// Accepts input transactions, steps both trigger phases and builds the
// event bundle of each transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module taet_front (
  input  wire                          clk,
  input  wire                          rst_n,
  input  taet_pkg::cfg_t               cfg,
  input  wire                          accept,
  input  wire                          func,
  input  wire [taet_pkg::FRAME_W-1:0]  sel_start,
  input  wire [taet_pkg::FRAME_W-1:0]  sel_stop,
  input  wire [taet_pkg::FRAME_W-1:0]  sqz_start,
  input  wire [taet_pkg::FRAME_W-1:0]  sqz_stop,
  input  wire [taet_pkg::LEVEL_W-1:0]  sel_level,
  input  wire [taet_pkg::LEVEL_W-1:0]  sqz_level,
  output logic                         push,
  output taet_pkg::evt_bundle_t        bundle
);
  import taet_pkg::*;

  typedef enum logic [1:0] {
    PH_RELEASED  = 2'd0,
    PH_PRESSING  = 2'd1,
    PH_PRESSED   = 2'd2,
    PH_RELEASING = 2'd3
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [1:0]  n;
    action_t     c0;
    action_t     c1;
  } trk_t;

  function automatic trk_t track(phase_t p, logic active, logic [LEVEL_W-1:0] lvl,
                                 cfg_t c, action_t a_start, action_t a_act,
                                 action_t a_end);
    trk_t r;
    r.phase = p;
    r.n     = 2'd0;
    r.c0    = a_end;
    r.c1    = a_end;
    if (active) begin
      if (p == PH_RELEASED && lvl > c.end_level) begin
        r.n = 2'd1; r.c0 = a_start; r.phase = PH_PRESSING;
      end else if (p == PH_PRESSING && lvl > c.complete_level) begin
        r.phase = PH_PRESSED;
      end else if (p == PH_PRESSED && lvl < c.start_level) begin
        r.n = 2'd1; r.c0 = a_act; r.phase = PH_RELEASING;
      end else if (p != PH_RELEASED && lvl < c.end_level) begin
        if (p == PH_PRESSED) begin
          r.n = 2'd2; r.c0 = a_act;
        end else begin
          r.n = 2'd1;
        end
        r.phase = PH_RELEASED;
      end
    end else if (p != PH_RELEASED) begin
      if (p == PH_PRESSED) begin
        r.n = 2'd2; r.c0 = a_act;
      end else begin
        r.n = 2'd1;
      end
      r.phase = PH_RELEASED;
    end
    return r;
  endfunction

  phase_t sel_phase_r, sel_phase_nxt;
  phase_t sqz_phase_r, sqz_phase_nxt;
  trk_t   sel_trk, sqz_trk;

  always_comb begin
    sel_trk = track(sel_phase_r, sel_start > sel_stop, sel_level, cfg,
                    ACT_SELECT_START, ACT_SELECT, ACT_SELECT_END);
    sqz_trk = track(sqz_phase_r, sqz_start > sqz_stop, sqz_level, cfg,
                    ACT_SQUEEZE_START, ACT_SQUEEZE, ACT_SQUEEZE_END);

    // unused channels keep their phase and stay quiet
    if (cfg.button_count < 7'd1) begin
      sel_trk.phase = sel_phase_r; sel_trk.n = 2'd0;
    end
    if (cfg.button_count < 7'd2) begin
      sqz_trk.phase = sqz_phase_r; sqz_trk.n = 2'd0;
    end

    // disconnect: only end events, no pending action
    if (func) begin
      sel_trk.phase = PH_RELEASED;
      sel_trk.n     = (sel_phase_r != PH_RELEASED) ? 2'd1 : 2'd0;
      sel_trk.c0    = ACT_SELECT_END;
      sqz_trk.phase = PH_RELEASED;
      sqz_trk.n     = (sqz_phase_r != PH_RELEASED) ? 2'd1 : 2'd0;
      sqz_trk.c0    = ACT_SQUEEZE_END;
    end

    sel_phase_nxt = accept ? sel_trk.phase : sel_phase_r;
    sqz_phase_nxt = accept ? sqz_trk.phase : sqz_phase_r;

    // select events first, squeeze events behind them
    bundle.count = {1'b0, sel_trk.n} + {1'b0, sqz_trk.n};
    bundle.codes = {sqz_trk.c1, sqz_trk.c0, sel_trk.c1, sel_trk.c0};
    case (sel_trk.n)
      2'd0:    bundle.codes = {sqz_trk.c1, sqz_trk.c1, sqz_trk.c1, sqz_trk.c0};
      2'd1:    bundle.codes = {sqz_trk.c1, sqz_trk.c1, sqz_trk.c0, sel_trk.c0};
      default: bundle.codes = {sqz_trk.c1, sqz_trk.c0, sel_trk.c1, sel_trk.c0};
    endcase
    if (sqz_trk.n == 2'd1) begin
      // single squeeze event sits in c0; shift c0 into the slot after select
      case (sel_trk.n)
        2'd0:    bundle.codes[0] = sqz_trk.c0;
        2'd1:    bundle.codes[1] = sqz_trk.c0;
        default: bundle.codes[2] = sqz_trk.c0;
      endcase
    end

    push = accept && (bundle.count != 3'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_phase_r <= PH_RELEASED;
      sqz_phase_r <= PH_RELEASED;
    end else begin
      sel_phase_r <= sel_phase_nxt;
      sqz_phase_r <= sqz_phase_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/taet_queue.sv -----
// ----------------------------------------------------------------------------
// taet_queue
// Short FIFO of event bundles between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module taet_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    push,
  input  taet_pkg::evt_bundle_t  push_data,
  input  wire                    pop,
  output logic                   full,
  output logic                   head_valid,
  output taet_pkg::evt_bundle_t  head
);
  import taet_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  evt_bundle_t      mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == FULL_CNT);
  assign head_valid = (cnt_r != '0);
  assign head       = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/taet_back.sv -----
// ----------------------------------------------------------------------------
// taet_back
// Drains the head bundle into the output register, one event per ready cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module taet_back (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    head_valid,
  input  taet_pkg::evt_bundle_t  head,
  output logic                   pop,
  output logic                   out_valid,
  input  wire                    out_ready,
  output taet_pkg::action_t      out_code,
  output logic                   out_last
);
  import taet_pkg::*;

  logic       out_valid_r, out_valid_nxt;
  action_t    out_code_r, out_code_nxt;
  logic       out_last_r, out_last_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       load, is_last;

  assign out_valid = out_valid_r;
  assign out_code  = out_code_r;
  assign out_last  = out_last_r;

  always_comb begin
    load          = !out_valid_r || out_ready;
    is_last       = ({1'b0, idx_r} == (head.count - 3'd1));
    out_valid_nxt = out_valid_r;
    out_code_nxt  = out_code_r;
    out_last_nxt  = out_last_r;
    idx_nxt       = idx_r;
    pop           = 1'b0;
    if (load) begin
      out_valid_nxt = head_valid;
      if (head_valid) begin
        out_code_nxt = head.codes[idx_r];
        out_last_nxt = is_last;
        if (is_last) begin
          idx_nxt = 2'd0;
          pop     = 1'b1;
        end else begin
          idx_nxt = idx_r + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
    out_code_r <= out_code_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

`default_nettype wire
